// ===== rtl/core/picr_pkg.sv =====
// ----------------------------------------------------------------------------
// picr_pkg
// shared types and constants of the pi current regulator with anti-windup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package picr_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int VAL_W  = 16;
    localparam int GAIN_W = 32;
    localparam int ERR_W  = VAL_W + 1;
    localparam int PROD_W = GAIN_W + 1 + ERR_W;
    localparam int ACC_W  = 48;
    localparam int SUM_W  = PROD_W + 1;
    localparam int UPD_W  = PROD_W + 2;
    localparam int FRAC_W = 24;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [2:0] REG_OUT_MAX   = 3'd0;
    localparam logic [2:0] REG_OUT_MIN   = 3'd1;
    localparam logic [2:0] REG_GAIN_PROP = 3'd2;
    localparam logic [2:0] REG_GAIN_INTG = 3'd3;
    localparam logic [2:0] REG_GAIN_BACK = 3'd4;

    localparam logic [VAL_W-1:0]  RST_OUT_MAX   = 16'd800;
    localparam logic [VAL_W-1:0]  RST_OUT_MIN   = 16'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_PROP = 32'd4194304;
    localparam logic [GAIN_W-1:0] RST_GAIN_INTG = 32'd1678;
    localparam logic [GAIN_W-1:0] RST_GAIN_BACK = 32'd6710886;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRIVE,
        ST_MULB,
        ST_UPDATE
    } picr_state_t;

    typedef struct packed {
        logic [VAL_W-1:0]  out_max;
        logic [VAL_W-1:0]  out_min;
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_backcalc;
    } picr_cfg_t;

    typedef struct packed {
        logic load_p;
        logic run_drive;
        logic run_mulb;
        logic run_update;
    } picr_cmd_t;

    typedef struct packed {
        logic out_busy;
    } picr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/picr_regs.sv =====
// ----------------------------------------------------------------------------
// picr_regs
// apb register file holding clamp limits and gains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module picr_regs
    import picr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output picr_cfg_t              cfg
);

    picr_cfg_t  cfg_reg;
    picr_cfg_t  cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_OUT_MAX:   cfg_next.out_max       = pwdata[VAL_W-1:0];
                REG_OUT_MIN:   cfg_next.out_min       = pwdata[VAL_W-1:0];
                REG_GAIN_PROP: cfg_next.gain_prop     = pwdata;
                REG_GAIN_INTG: cfg_next.gain_integ    = pwdata;
                REG_GAIN_BACK: cfg_next.gain_backcalc = pwdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_max       <= RST_OUT_MAX;
            cfg_reg.out_min       <= RST_OUT_MIN;
            cfg_reg.gain_prop     <= RST_GAIN_PROP;
            cfg_reg.gain_integ    <= RST_GAIN_INTG;
            cfg_reg.gain_backcalc <= RST_GAIN_BACK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_OUT_MAX:   prdata = {{(DATA_W-VAL_W){cfg_reg.out_max[VAL_W-1]}},
                                     cfg_reg.out_max};
            REG_OUT_MIN:   prdata = {{(DATA_W-VAL_W){cfg_reg.out_min[VAL_W-1]}},
                                     cfg_reg.out_min};
            REG_GAIN_PROP: prdata = cfg_reg.gain_prop;
            REG_GAIN_INTG: prdata = cfg_reg.gain_integ;
            REG_GAIN_BACK: prdata = cfg_reg.gain_backcalc;
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/picr_ctrl.sv =====
// ----------------------------------------------------------------------------
// picr_ctrl
// sequencer stepping one item through the shared multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module picr_ctrl
    import picr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire picr_sts_t sts,
    output picr_cmd_t      cmd
);

    picr_state_t state_reg;
    picr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_p = 1'b1;
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE:
            begin
                // wait while the previous item still sits in the output register
                if (!sts.out_busy)
                begin
                    cmd.run_drive = 1'b1;
                    state_next    = ST_MULB;
                end
            end
            ST_MULB:
            begin
                cmd.run_mulb = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.run_update = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/picr_dp.sv =====
// ----------------------------------------------------------------------------
// picr_dp
// error, shared gain multiplier, clamp, integral update and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module picr_dp
    import picr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [VAL_W-1:0] setpoint,
    input  wire logic [VAL_W-1:0] measured_current,
    input  wire picr_cfg_t        cfg,
    input  wire picr_cmd_t        cmd,
    output picr_sts_t             sts,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [VAL_W-1:0] drive
);

    logic        [VAL_W-1:0]  diff;
    logic signed [ERR_W-1:0]  err_in;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  exc_reg;
    logic signed [ERR_W-1:0]  exc_next;
    logic                     zero_reg;
    logic        [GAIN_W-1:0] mult_a;
    logic signed [ERR_W-1:0]  mult_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  integ_reg;
    logic signed [ACC_W-1:0]  integ_eff;
    logic signed [ACC_W-1:0]  integ_next;
    logic signed [SUM_W-1:0]  sum;
    logic                     corr;
    logic signed [VAL_W-1:0]  raw;
    logic signed [VAL_W-1:0]  drv_next;
    logic signed [UPD_W-1:0]  acc_reg;
    logic signed [UPD_W-1:0]  upd;
    logic        [VAL_W-1:0]  drive_reg;
    logic                     out_valid_reg;

    assign diff   = setpoint - measured_current;
    assign err_in = {diff[VAL_W-1], diff};

    // operand select for the shared multiplier
    always_comb
    begin
        if (cmd.load_p)
        begin
            mult_a = cfg.gain_prop;
            mult_b = err_in;
        end
        else if (cmd.run_drive)
        begin
            mult_a = cfg.gain_integ;
            mult_b = err_reg;
        end
        else
        begin
            mult_a = cfg.gain_backcalc;
            mult_b = exc_reg;
        end
    end

    assign prod_next = $signed({1'b0, mult_a}) * mult_b;

    assign integ_eff = zero_reg ? '0 : integ_reg;

    // raw drive: integral plus proportional term, truncated toward zero
    assign sum  = {{(SUM_W-ACC_W){integ_eff[ACC_W-1]}}, integ_eff}
                + {prod_reg[PROD_W-1], prod_reg};
    assign corr = sum[SUM_W-1] && (|sum[FRAC_W-1:0]);
    assign raw  = sum[FRAC_W+VAL_W-1:FRAC_W] + {{(VAL_W-1){1'b0}}, corr};

    always_comb
    begin
        if (raw > $signed(cfg.out_max))
        begin
            drv_next = $signed(cfg.out_max);
        end
        else if (raw < $signed(cfg.out_min))
        begin
            drv_next = $signed(cfg.out_min);
        end
        else
        begin
            drv_next = raw;
        end
    end

    assign exc_next = {raw[VAL_W-1], raw} - {drv_next[VAL_W-1], drv_next};

    // integral update with saturation to the accumulator range
    assign upd = acc_reg - {{(UPD_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        if ((&upd[UPD_W-1:ACC_W-1]) || !(|upd[UPD_W-1:ACC_W-1]))
        begin
            integ_next = upd[ACC_W-1:0];
        end
        else if (upd[UPD_W-1])
        begin
            integ_next = ACC_MIN;
        end
        else
        begin
            integ_next = ACC_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_p)
        begin
            err_reg  <= err_in;
            zero_reg <= (setpoint == '0);
        end
        if (cmd.load_p || cmd.run_drive || cmd.run_mulb)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.run_drive)
        begin
            exc_reg   <= exc_next;
            drive_reg <= drv_next;
            acc_reg   <= {{(UPD_W-ACC_W){integ_eff[ACC_W-1]}}, integ_eff};
        end
        if (cmd.run_mulb)
        begin
            acc_reg <= acc_reg + {{(UPD_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.run_update)
            begin
                integ_reg <= integ_next;
            end
            if (cmd.run_drive)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_busy = out_valid_reg && out_stall;
    assign out_valid    = out_valid_reg;
    assign drive        = drive_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pi_current_regulator_antiwindup_core.sv =====
// ----------------------------------------------------------------------------
// pi_current_regulator_antiwindup_core
// pi current regulator with clamped output and back-calculation anti-windup
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid / in_stall   setpoint, measured_current
// out      output     out_valid / out_stall drive
// cfg      input      apb psel / penable    paddr, pwdata, prdata
//
// the one 33x17 multiplier forms three products in the idle, drive and mulb steps
// drive is registered in the drive step once the output register is free
// reset loads the default limits and gains and clears the integral
// a stalled output holds the next item in its drive step until the register frees
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pi_current_regulator_antiwindup_core
    import picr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [VAL_W-1:0]  setpoint,
    input  wire logic [VAL_W-1:0]  measured_current,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [VAL_W-1:0]  drive,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    picr_cfg_t cfg;
    picr_cmd_t cmd;
    picr_sts_t sts;

    picr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    picr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    picr_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .setpoint         (setpoint),
        .measured_current (measured_current),
        .cfg              (cfg),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive            (drive)
    );

endmodule

`default_nettype wire
